>>> rtl/iabr_pkg.sv
package iabr_pkg;

   // Largest icon side the counters cover.
   localparam int MAX_ICON_SIDE = 1024;

   // Field widths.
   localparam int CNT_W      = (MAX_ICON_SIDE > 1) ? $clog2(MAX_ICON_SIDE) : 1;
   localparam int SIZE_W     = 11;
   localparam int ORG_W      = 12;
   localparam int COORD_W    = 13;
   localparam int CHAN_W     = 8;
   localparam int RGB_W      = 3 * CHAN_W;
   localparam int PIXEL_W    = 4 * CHAN_W;
   localparam int PROD_W     = 2 * CHAN_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Width that holds both a configured size and a counter plus one.
   localparam int SIDE_W = (CNT_W + 1 > SIZE_W) ? CNT_W + 1 : SIZE_W;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ICON_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ICON_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [SIZE_W-1:0] ICON_WIDTH_RESET  = 11'd32;
   localparam logic [SIZE_W-1:0] ICON_HEIGHT_RESET = 11'd32;

   // Alpha codes with special meaning.
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE      = 8'hFF;
   localparam logic [CHAN_W-1:0] ALPHA_TRANSPARENT = 8'h00;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // How the back has to treat a pixel.
   typedef enum logic [1:0] {
      CLS_SKIP  = 2'd0,
      CLS_COPY  = 2'd1,
      CLS_BLEND = 2'd2
   } blend_class_type;

   // One classified pixel as it travels from the front to the back.
   typedef struct packed {
      logic [COORD_W-1:0] screen_x;
      logic [COORD_W-1:0] screen_y;
      logic               last;
      blend_class_type    cls;
      logic [CHAN_W-1:0]  alpha;
      logic [RGB_W-1:0]   fg;
      logic [RGB_W-1:0]   bg;
   } item_type;

   // A size of zero acts as one, a size above the maximum as the maximum.
   function automatic logic [SIDE_W-1:0] effective_side(input logic [SIZE_W-1:0] v);
      logic [SIDE_W-1:0] ext;
      ext = SIDE_W'(v);
      if (v == '0) begin
         return SIDE_W'(1);
      end else if (ext > SIDE_W'(MAX_ICON_SIDE)) begin
         return SIDE_W'(MAX_ICON_SIDE);
      end else begin
         return ext;
      end
   endfunction

   // Exact x / 255 for any product of two bytes: (x + (x >> 8) + 1) >> 8.
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] t;
      t = {1'b0, x} + (PROD_W+1)'(x[PROD_W-1:CHAN_W]) + (PROD_W+1)'(1);
      return t[PROD_W-1:CHAN_W];
   endfunction

endpackage

>>> rtl/icon_alpha_blend_raster.sv
// Source-over blender for an ARGB8888 icon drawn onto an RGB888 screen.
// Request channel: one word per icon pixel in raster order, the ARGB pixel
// together with the screen RGB currently found at its position.
// Response channel: one word per request, in order, carrying the screen
// coordinate (origin plus column and row), a write flag that is low for
// fully transparent pixels, the RGB to write, and a flag on the icon's last
// pixel. Configuration channel: icon width, icon height and origin, indexed
// 0 to 3; it is always ready. It must be written only while no pixel is in
// flight; the block itself does not enforce this. A taken request passes the
// queue, the product stage and the output register in that order. Throughput:
// one pixel per clock while responses are taken, set by the single product
// stage of three channel multiplier pairs that every pixel passes once.
// A four-word queue separates the counting front from the blending back.
// With the product stage and the output register the block holds six words,
// so requests keep flowing for up to six words while the receiver stalls;
// once it is full, req_ready drops and rises again the cycle after a
// response is taken.
// Reset clears the raster counters, empties the queue and pipeline, and loads
// a 32 by 32 icon at origin zero.
module icon_alpha_blend_raster (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [iabr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [iabr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [iabr_pkg::PIXEL_W-1:0]     req_icon_pixel,
   input  logic [iabr_pkg::RGB_W-1:0]       req_background_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [iabr_pkg::COORD_W-1:0]     rsp_screen_x,
   output logic [iabr_pkg::COORD_W-1:0]     rsp_screen_y,
   output logic                             rsp_write_pixel,
   output logic [iabr_pkg::RGB_W-1:0]       rsp_pixel_color,
   output logic                             rsp_last_pixel
);
   import iabr_pkg::*;

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   // Counting and classification.
   iabr_front u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_icon_pixel       (req_icon_pixel),
      .req_background_pixel (req_background_pixel),
      .push_valid           (push_valid),
      .push_ready           (push_ready),
      .push_item            (push_item)
   );

   // Decoupling queue.
   iabr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Blending and response register.
   iabr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_item        (pop_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_write_pixel (rsp_write_pixel),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule

>>> rtl/iabr_front.sv
module iabr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [iabr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [iabr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [iabr_pkg::PIXEL_W-1:0]     req_icon_pixel,
   input  logic [iabr_pkg::RGB_W-1:0]       req_background_pixel,
   output logic                             push_valid,
   input  logic                             push_ready,
   output iabr_pkg::item_type               push_item
);
   import iabr_pkg::*;

   logic [SIZE_W-1:0] icon_width_ff, icon_width_in;
   logic [SIZE_W-1:0] icon_height_ff, icon_height_in;
   logic [ORG_W-1:0]  origin_x_ff, origin_x_in;
   logic [ORG_W-1:0]  origin_y_ff, origin_y_in;
   logic [CNT_W-1:0]  column_ff, column_in;
   logic [CNT_W-1:0]  row_ff, row_in;

   logic              accept;
   logic [SIDE_W-1:0] width_eff;
   logic [SIDE_W-1:0] height_eff;
   logic              col_end;
   logic              row_end;
   logic [CHAN_W-1:0] alpha;

   // Registers are always writable; the port must see writes only while idle, which is not enforced here.
   assign csr_ready = 1'b1;

   always_comb begin
      icon_width_in  = icon_width_ff;
      icon_height_in = icon_height_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ICON_WIDTH:  icon_width_in  = csr_wdata[SIZE_W-1:0];
            CSR_ICON_HEIGHT: icon_height_in = csr_wdata[SIZE_W-1:0];
            CSR_ORIGIN_X:    origin_x_in    = csr_wdata[ORG_W-1:0];
            CSR_ORIGIN_Y:    origin_y_in    = csr_wdata[ORG_W-1:0];
            default: ;
         endcase
      end
   end

   // A word is taken whenever the queue has room.
   assign req_ready  = push_ready;
   assign accept     = req_valid && push_ready;
   assign push_valid = req_valid;

   // Raster position. A counter already past a shrunken size counts as at the end.
   assign width_eff  = effective_side(icon_width_ff);
   assign height_eff = effective_side(icon_height_ff);
   assign col_end    = (SIDE_W'(column_ff) + SIDE_W'(1)) >= width_eff;
   assign row_end    = (SIDE_W'(row_ff) + SIDE_W'(1)) >= height_eff;

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (col_end) begin
            column_in = '0;
            row_in    = row_end ? '0 : row_ff + CNT_W'(1);
         end else begin
            column_in = column_ff + CNT_W'(1);
         end
      end
   end

   // Classify by alpha and attach the screen coordinate.
   assign alpha = req_icon_pixel[PIXEL_W-1:RGB_W];

   always_comb begin
      push_item.screen_x = COORD_W'(origin_x_ff) + COORD_W'(column_ff);
      push_item.screen_y = COORD_W'(origin_y_ff) + COORD_W'(row_ff);
      push_item.last     = col_end && row_end;
      push_item.alpha    = alpha;
      push_item.fg       = req_icon_pixel[RGB_W-1:0];
      push_item.bg       = req_background_pixel;
      if (alpha == ALPHA_OPAQUE) begin
         push_item.cls = CLS_COPY;
      end else if (alpha == ALPHA_TRANSPARENT) begin
         push_item.cls = CLS_SKIP;
      end else begin
         push_item.cls = CLS_BLEND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         icon_width_ff  <= ICON_WIDTH_RESET;
         icon_height_ff <= ICON_HEIGHT_RESET;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         column_ff      <= '0;
         row_ff         <= '0;
      end else begin
         icon_width_ff  <= icon_width_in;
         icon_height_ff <= icon_height_in;
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
      end
   end

endmodule

>>> rtl/iabr_queue.sv
module iabr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  iabr_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output iabr_pkg::item_type pop_item
);
   import iabr_pkg::*;

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointers wrap over the power-of-two depth.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/iabr_back.sv
module iabr_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  iabr_pkg::item_type             pop_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [iabr_pkg::COORD_W-1:0]   rsp_screen_x,
   output logic [iabr_pkg::COORD_W-1:0]   rsp_screen_y,
   output logic                           rsp_write_pixel,
   output logic [iabr_pkg::RGB_W-1:0]     rsp_pixel_color,
   output logic                           rsp_last_pixel
);
   import iabr_pkg::*;

   // Product stage.
   logic               s1_valid_ff, s1_valid_in;
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff;
   logic               s1_last_ff;
   blend_class_type    s1_cls_ff;
   logic [RGB_W-1:0]   s1_fg_ff;
   logic [PROD_W-1:0]  s1_pf_ff [3];
   logic [PROD_W-1:0]  s1_pb_ff [3];

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic               rsp_write_ff;
   logic [RGB_W-1:0]   rsp_color_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               s1_free;
   logic               s1_move;
   logic               pop;
   logic [CHAN_W-1:0]  inv_alpha;
   logic [RGB_W-1:0]   blend_color;
   logic [RGB_W-1:0]   color_in;

   // The pipeline advances wherever the stage ahead is empty or draining.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || out_free;
   assign pop_ready = s1_free;
   assign pop       = pop_valid && s1_free;

   assign s1_valid_in  = s1_free ? pop_valid : s1_valid_ff;
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   // 255 - a is the bitwise inverse of an 8-bit alpha.
   assign inv_alpha = ~pop_item.alpha;

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_x_ff    <= pop_item.screen_x;
         s1_y_ff    <= pop_item.screen_y;
         s1_last_ff <= pop_item.last;
         s1_cls_ff  <= pop_item.cls;
         s1_fg_ff   <= pop_item.fg;
         for (int c = 0; c < 3; c++) begin
            s1_pf_ff[c] <= PROD_W'(pop_item.fg[c*CHAN_W +: CHAN_W]) * PROD_W'(pop_item.alpha);
            s1_pb_ff[c] <= PROD_W'(pop_item.bg[c*CHAN_W +: CHAN_W]) * PROD_W'(inv_alpha);
         end
      end
   end

   // Each term is truncated on its own; the sum stays within a byte.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         blend_color[c*CHAN_W +: CHAN_W] = div255(s1_pf_ff[c]) + div255(s1_pb_ff[c]);
      end
      case (s1_cls_ff)
         CLS_COPY:  color_in = s1_fg_ff;
         CLS_BLEND: color_in = blend_color;
         CLS_SKIP:  color_in = '0;
         default:   color_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_x_ff     <= s1_x_ff;
         rsp_y_ff     <= s1_y_ff;
         rsp_last_ff  <= s1_last_ff;
         rsp_write_ff <= s1_cls_ff != CLS_SKIP;
         rsp_color_ff <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_screen_x    = rsp_x_ff;
   assign rsp_screen_y    = rsp_y_ff;
   assign rsp_write_pixel = rsp_write_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

endmodule

>>> test/tb_icon_alpha_blend_raster.sv
module tb_icon_alpha_blend_raster;
   import iabr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int TARGET_ITEMS = 1450;
   localparam int LONG_HOLD    = 64;
   localparam int SETTLE       = 8;

   // One word on the result channel, as the screen writer sees it.
   typedef struct packed {
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic               wr;
      logic [RGB_W-1:0]   color;
      logic               last;
   } screen_word_type;

   // A hand-picked pixel; color and write flag are typed in where they are obvious.
   typedef struct {
      logic [PIXEL_W-1:0] pix;
      logic [RGB_W-1:0]   bg;
      bit                 typed;
      bit                 wr;
      logic [RGB_W-1:0]   color;
   } pixel_case_type;

   typedef enum {
      READY_ALWAYS,
      READY_COIN,
      READY_EVERY_THIRD,
      READY_MOSTLY
   } stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIXEL_W-1:0]    req_icon_pixel = '0;
   logic [RGB_W-1:0]      req_background_pixel = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COORD_W-1:0]    rsp_screen_x;
   logic [COORD_W-1:0]    rsp_screen_y;
   logic                  rsp_write_pixel;
   logic [RGB_W-1:0]      rsp_pixel_color;
   logic                  rsp_last_pixel;

   // Shadow of the block's registers and raster position.
   logic [SIZE_W-1:0] size_w = ICON_WIDTH_RESET;
   logic [SIZE_W-1:0] size_h = ICON_HEIGHT_RESET;
   logic [ORG_W-1:0]  org_x = '0;
   logic [ORG_W-1:0]  org_y = '0;
   int                col_pos = 0;
   int                row_pos = 0;

   screen_word_type writes_due [$];
   screen_word_type got_word;
   screen_word_type want_word;

   int cycle_count = 0;
   int mismatches = 0;
   int pixels_taken = 0;
   int words_seen = 0;
   int icons_done = 0;
   int n_opaque = 0;
   int n_clear = 0;
   int n_blend = 0;
   int n_settings = 0;
   int burst_left = 0;
   int hold_trig = 0;

   pixel_case_type pixel_cases [18] = '{
      '{32'hFF000000, 24'hFFFFFF, 1'b1, 1'b1, 24'h000000},
      '{32'hFFFFFFFF, 24'h000000, 1'b1, 1'b1, 24'hFFFFFF},
      '{32'hFF123456, 24'hABCDEF, 1'b1, 1'b1, 24'h123456},
      '{32'h00FFFFFF, 24'hFFFFFF, 1'b1, 1'b0, 24'h000000},
      '{32'h00000000, 24'h000000, 1'b1, 1'b0, 24'h000000},
      '{32'h00A5C3E7, 24'h5A3C18, 1'b1, 1'b0, 24'h000000},
      '{32'h01FFFFFF, 24'h000000, 1'b0, 1'b0, 24'h000000},
      '{32'hFEFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
      '{32'h80FFFFFF, 24'h000000, 1'b0, 1'b0, 24'h000000},
      '{32'h80000000, 24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
      '{32'h7FAA55AA, 24'h55AA55, 1'b0, 1'b0, 24'h000000},
      '{32'h01000000, 24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
      '{32'hFE000000, 24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
      '{32'h80808080, 24'h808080, 1'b0, 1'b0, 24'h000000},
      '{32'h55123456, 24'hFEDCBA, 1'b0, 1'b0, 24'h000000},
      '{32'hAAFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
      '{32'hC0010203, 24'hFDFEFF, 1'b0, 1'b0, 24'h000000},
      '{32'h40FF00FF, 24'h00FF00, 1'b0, 1'b0, 24'h000000}
   };

   icon_alpha_blend_raster u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_icon_pixel       (req_icon_pixel),
      .req_background_pixel (req_background_pixel),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_screen_x         (rsp_screen_x),
      .rsp_screen_y         (rsp_screen_y),
      .rsp_write_pixel      (rsp_write_pixel),
      .rsp_pixel_color      (rsp_pixel_color),
      .rsp_last_pixel       (rsp_last_pixel)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // A size of zero behaves as one, anything above the largest side as that side.
   function automatic int clamp_side(input logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return 1;
      end else if (int'(v) > MAX_ICON_SIDE) begin
         return MAX_ICON_SIDE;
      end
      return int'(v);
   endfunction

   // Works out the screen word for one icon pixel and steps the raster position.
   function automatic screen_word_type place_pixel(input logic [PIXEL_W-1:0] pix,
                                                   input logic [RGB_W-1:0] bg);
      screen_word_type w;
      int alpha;
      int fg;
      int bgc;
      int sum;
      bit col_end;
      bit row_end;
      alpha = int'(pix[31:24]);
      col_end = (col_pos + 1 >= clamp_side(size_w));
      row_end = (row_pos + 1 >= clamp_side(size_h));
      w.sx = COORD_W'(int'(org_x) + col_pos);
      w.sy = COORD_W'(int'(org_y) + row_pos);
      w.last = col_end && row_end;
      if (pix[31:24] == ALPHA_OPAQUE) begin
         w.wr = 1'b1;
         w.color = pix[RGB_W-1:0];
      end else if (pix[31:24] == ALPHA_TRANSPARENT) begin
         w.wr = 1'b0;
         w.color = '0;
      end else begin
         // Each of the two terms is truncated on its own before the sum.
         w.wr = 1'b1;
         for (int ch = 0; ch < 3; ch++) begin
            fg = int'(pix[8*ch +: 8]);
            bgc = int'(bg[8*ch +: 8]);
            sum = (fg * alpha) / 255 + (bgc * (255 - alpha)) / 255;
            w.color[8*ch +: 8] = sum[7:0];
         end
      end
      if (col_end) begin
         col_pos = 0;
         row_pos = row_end ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return w;
   endfunction

   // Mostly plain opaque or clear pixels and arbitrary alphas, with the near-extremes.
   function automatic logic [PIXEL_W-1:0] random_argb();
      logic [PIXEL_W-1:0] p;
      int sel;
      p = $urandom();
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
         p[31:24] = ALPHA_OPAQUE;
      end else if (sel < 4) begin
         p[31:24] = ALPHA_TRANSPARENT;
      end else if (sel == 4) begin
         p[31:24] = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
      end
      return p;
   endfunction

   // Size register data; bit 11 carries junk that the block must drop.
   function automatic logic [CSR_DATA_W-1:0] random_size();
      int sel;
      int v;
      sel = $urandom_range(0, 15);
      case (sel)
         0: v = 0;
         1: v = 1;
         2: v = MAX_ICON_SIDE;
         3: v = $urandom_range(MAX_ICON_SIDE + 1, 2047);
         default: v = $urandom_range(1, 7);
      endcase
      return {1'($urandom_range(0, 1)), SIZE_W'(v)};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_origin();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) begin
         return '0;
      end else if (sel == 1) begin
         return '1;
      end
      return CSR_DATA_W'($urandom_range(0, 4095));
   endfunction

   // Sender bursts: idle for a random gap whenever a burst runs out.
   task automatic pace_sender(input bit steady);
      int gap;
      if (steady) begin
         return;
      end
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // Offers one pixel word and records what the screen should get once it is taken.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic [RGB_W-1:0] bg,
                             input bit typed, input bit wr, input logic [RGB_W-1:0] color);
      screen_word_type w;
      @(negedge clock);
      req_valid <= 1'b1;
      req_icon_pixel <= pix;
      req_background_pixel <= bg;
      do @(posedge clock); while (!req_ready);
      w = place_pixel(pix, bg);
      if (typed) begin
         w.wr = wr;
         w.color = color;
      end
      writes_due.push_back(w);
      pixels_taken++;
      if (w.last) begin
         icons_done++;
      end
      if (pix[31:24] == ALPHA_OPAQUE) begin
         n_opaque++;
      end else if (pix[31:24] == ALPHA_TRANSPARENT) begin
         n_clear++;
      end else begin
         n_blend++;
      end
   endtask

   // Stops offering and waits until every pixel in flight has come out.
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (writes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ICON_WIDTH:  size_w = data[SIZE_W-1:0];
         CSR_ICON_HEIGHT: size_h = data[SIZE_W-1:0];
         CSR_ORIGIN_X:    org_x = data[ORG_W-1:0];
         CSR_ORIGIN_Y:    org_y = data[ORG_W-1:0];
         default: ;
      endcase
   endtask

   // One icon setting: drain, reprogram while idle, then stream random pixels.
   task automatic run_phase(input logic [CSR_DATA_W-1:0] wd, input logic [CSR_DATA_W-1:0] hd,
                            input logic [CSR_DATA_W-1:0] ox, input logic [CSR_DATA_W-1:0] oy,
                            input int n_items, input bit hold);
      drain_block();
      write_csr(CSR_ICON_WIDTH, wd);
      write_csr(CSR_ICON_HEIGHT, hd);
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      @(negedge clock);
      csr_valid <= 1'b0;
      n_settings++;
      // Ask the receiver for a long stall while pixels keep coming back to back.
      if (hold) begin
         hold_trig++;
      end
      for (int i = 0; i < n_items; i++) begin
         pace_sender(hold);
         send_pixel(random_argb(), RGB_W'($urandom()), 1'b0, 1'b0, '0);
      end
   endtask

   // Receiver: switches between stall patterns, and holds off on request.
   initial begin : receiver
      stall_mode_type mode;
      int left;
      int hold_left;
      int seen;
      int tick;
      mode = READY_ALWAYS;
      left = 0;
      hold_left = 0;
      seen = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_trig != seen) begin
            seen = hold_trig;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
               READY_ALWAYS:      rsp_ready <= 1'b1;
               READY_COIN:        rsp_ready <= 1'($urandom_range(0, 1));
               READY_EVERY_THIRD: rsp_ready <= (tick % 3 == 0);
               default:           rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Compares each screen word taken from the block with the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         got_word = '{rsp_screen_x, rsp_screen_y, rsp_write_pixel, rsp_pixel_color,
                      rsp_last_pixel};
         if (writes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected word: x=%0d y=%0d wr=%b color=%h last=%b",
                        got_word.sx, got_word.sy, got_word.wr, got_word.color,
                        got_word.last);
            end
         end else begin
            want_word = writes_due.pop_front();
            if (got_word !== want_word) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("word %0d: expected x=%0d y=%0d wr=%b color=%h last=%b",
                           words_seen, want_word.sx, want_word.sy, want_word.wr,
                           want_word.color, want_word.last);
                  $display("word %0d:   actual x=%0d y=%0d wr=%b color=%h last=%b",
                           words_seen, got_word.sx, got_word.sy, got_word.wr,
                           got_word.color, got_word.last);
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycle_count,
                  writes_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] wd;
      logic [CSR_DATA_W-1:0] hd;
      int ew;
      int eh;
      int area;
      int n;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Hand-picked pixels on the reset icon setting.
      foreach (pixel_cases[i]) begin
         pace_sender(1'b0);
         send_pixel(pixel_cases[i].pix, pixel_cases[i].bg, pixel_cases[i].typed,
                    pixel_cases[i].wr, pixel_cases[i].color);
      end

      // Shrink the icon below the current column, at the far corner of the screen.
      run_phase(12'h804, 12'd3, 12'hFFF, 12'hFFF, 30, 1'b0);
      // Zero sizes act as a one-pixel icon.
      run_phase(12'd0, 12'h800, 12'd0, 12'd0, 12, 1'b0);
      // Oversized width clamps to the largest side; receiver stalls long here.
      run_phase(12'h7FF, 12'd2, 12'hFFF, 12'd0, 40, 1'b1);
      run_phase(12'd1024, 12'd1024, 12'd123, 12'hFFF, 30, 1'b0);
      run_phase(12'd1, 12'd5, 12'd7, 12'd9, 15, 1'b0);

      // Random settings, mostly small icons walked to completion at least once.
      while (pixels_taken < TARGET_ITEMS) begin
         wd = random_size();
         hd = random_size();
         ew = clamp_side(wd[SIZE_W-1:0]);
         eh = clamp_side(hd[SIZE_W-1:0]);
         area = ew * eh;
         if (ew <= 8 && eh <= 8) begin
            n = area * $urandom_range(1, 3) + $urandom_range(0, area);
         end else begin
            n = $urandom_range(10, 50);
         end
         run_phase(wd, hd, random_origin(), random_origin(), n,
                   $urandom_range(0, 15) == 0);
      end

      drain_block();
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d pixels over %0d icon settings, %0d icons completed.",
               pixels_taken, n_settings, icons_done);
      $display("Pixels by alpha: %0d opaque, %0d clear, %0d blended; %0d mismatches.",
               n_opaque, n_clear, n_blend, mismatches);
      if (mismatches == 0 && writes_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/iabr_pkg.sv
rtl/iabr_front.sv
rtl/iabr_queue.sv
rtl/iabr_back.sv
rtl/icon_alpha_blend_raster.sv
test/tb_icon_alpha_blend_raster.sv
